### hw/rtl/tdad_pkg.sv
// Shared types, step tables and constants for the table DPCM audio decoder.
// No dependencies; imported by tdad_step and table_dpcm_audio_decoder_top.
package tdad_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CODE_W   = 8;

	// Start values of the accumulator at the head of a resource.
	localparam logic signed [SAMPLE_W-1:0] START_16 = 16'sd0;
	localparam logic signed [SAMPLE_W-1:0] START_8  = 16'sd128;

	// Limits of the two modes.
	localparam logic signed [17:0] SAT_HI = 18'sd32767;
	localparam logic signed [17:0] SAT_LO = -18'sd32768;
	localparam logic signed [16:0] CLAMP_HI = 17'sd255;
	localparam logic signed [16:0] CLAMP_LO = 17'sd0;

	// Step table of the 16-bit mode, indexed by the low seven bits of a code.
	localparam logic [15:0] STEP16 [128] = '{
		16'h0000, 16'h0008, 16'h0010, 16'h0020, 16'h0030, 16'h0040, 16'h0050, 16'h0060,
		16'h0070, 16'h0080, 16'h0090, 16'h00A0, 16'h00B0, 16'h00C0, 16'h00D0, 16'h00E0,
		16'h00F0, 16'h0100, 16'h0110, 16'h0120, 16'h0130, 16'h0140, 16'h0150, 16'h0160,
		16'h0170, 16'h0180, 16'h0190, 16'h01A0, 16'h01B0, 16'h01C0, 16'h01D0, 16'h01E0,
		16'h01F0, 16'h0200, 16'h0208, 16'h0210, 16'h0218, 16'h0220, 16'h0228, 16'h0230,
		16'h0238, 16'h0240, 16'h0248, 16'h0250, 16'h0258, 16'h0260, 16'h0268, 16'h0270,
		16'h0278, 16'h0280, 16'h0288, 16'h0290, 16'h0298, 16'h02A0, 16'h02A8, 16'h02B0,
		16'h02B8, 16'h02C0, 16'h02C8, 16'h02D0, 16'h02D8, 16'h02E0, 16'h02E8, 16'h02F0,
		16'h02F8, 16'h0300, 16'h0308, 16'h0310, 16'h0318, 16'h0320, 16'h0328, 16'h0330,
		16'h0338, 16'h0340, 16'h0348, 16'h0350, 16'h0358, 16'h0360, 16'h0368, 16'h0370,
		16'h0378, 16'h0380, 16'h0388, 16'h0390, 16'h0398, 16'h03A0, 16'h03A8, 16'h03B0,
		16'h03B8, 16'h03C0, 16'h03C8, 16'h03D0, 16'h03D8, 16'h03E0, 16'h03E8, 16'h03F0,
		16'h03F8, 16'h0400, 16'h0440, 16'h0480, 16'h04C0, 16'h0500, 16'h0540, 16'h0580,
		16'h05C0, 16'h0600, 16'h0640, 16'h0680, 16'h06C0, 16'h0700, 16'h0740, 16'h0780,
		16'h07C0, 16'h0800, 16'h0900, 16'h0A00, 16'h0B00, 16'h0C00, 16'h0D00, 16'h0E00,
		16'h0F00, 16'h1000, 16'h1400, 16'h1800, 16'h1C00, 16'h2000, 16'h3000, 16'h4000
	};

	// Step table of the 8-bit nibble mode.
	localparam logic [4:0] STEP8 [8] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd6, 5'd10, 5'd15, 5'd21};

	// Control handed to the step datapath.
	typedef struct packed {
		logic mode16;   // 1: 16-bit mode
		logic restart;  // accumulator takes the start value first
		logic phase;    // 8-bit mode: 0 high nibble, 1 low nibble
	} step_ctl_t;

	// One result beat.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} step_res_t;

endpackage

### hw/rtl/tdad_step.sv
// Combinational step of the decoder: start value, table look-up, add or
// subtract and saturation. Depends on tdad_pkg.
module tdad_step (
	input  logic signed [tdad_pkg::SAMPLE_W-1:0] acc,
	input  logic [tdad_pkg::CODE_W-1:0]          code_byte,
	input  tdad_pkg::step_ctl_t                  ctl,
	output tdad_pkg::step_res_t                  res
);
	import tdad_pkg::*;

	logic signed [SAMPLE_W-1:0] base;
	logic [15:0]                mag16;
	logic signed [17:0]         sum16;
	logic signed [SAMPLE_W-1:0] sat16;
	logic [3:0]                 nib;
	logic [2:0]                 idx8;
	logic [4:0]                 mag8;
	logic signed [16:0]         sum8;
	logic signed [SAMPLE_W-1:0] clamp8;

	always_comb begin
		base = ctl.restart ? (ctl.mode16 ? START_16 : START_8) : acc;

		// 16-bit mode: signed step from the large table, saturate.
		mag16 = STEP16[code_byte[6:0]];
		if (code_byte[7]) begin
			sum16 = {{2{base[15]}}, base} - $signed({2'b00, mag16});
		end else begin
			sum16 = {{2{base[15]}}, base} + $signed({2'b00, mag16});
		end
		if (sum16 > SAT_HI) begin
			sat16 = SAT_HI[15:0];
		end else if (sum16 < SAT_LO) begin
			sat16 = SAT_LO[15:0];
		end else begin
			sat16 = sum16[15:0];
		end

		// 8-bit mode: a subtract nibble reads the small table in reverse.
		nib  = ctl.phase ? code_byte[3:0] : code_byte[7:4];
		idx8 = nib[3] ? ~nib[2:0] : nib[2:0];
		mag8 = STEP8[idx8];
		if (nib[3]) begin
			sum8 = {base[15], base} - $signed({12'd0, mag8});
		end else begin
			sum8 = {base[15], base} + $signed({12'd0, mag8});
		end
		if (sum8 > CLAMP_HI) begin
			clamp8 = CLAMP_HI[15:0];
		end else if (sum8 < CLAMP_LO) begin
			clamp8 = CLAMP_LO[15:0];
		end else begin
			clamp8 = sum8[15:0];
		end

		res.sample = ctl.mode16 ? sat16 : clamp8;
		res.last   = ctl.mode16 | ctl.phase;
	end

endmodule

### hw/rtl/table_dpcm_audio_decoder_top.sv
// Top level of the table DPCM audio decoder: input register, accumulator,
// output register and configuration register. Depends on tdad_pkg, tdad_step.
//
//  Channel  Direction  Beat                  Payload
//  s_axis   in         one code byte         tdata[7:0] code_byte, tlast end_of_resource
//  m_axis   out        one decoded sample    tdata[15:0] sample, tlast last_of_run
//  cfg      in         mode register write   cfg_data sixteen_bit_mode
//
// In 16-bit mode a byte gives one sample, so bytes flow at one per cycle while the
// output is not stalled. In 8-bit mode a byte stays in the input register until the
// step datapath has given a sample for each nibble, high nibble first, and the next
// byte is taken only as the low nibble's sample is written; the shared step datapath
// and the single output register set that. A byte passes the input register, then the output register.
// Reset clears the valid flags, loads the mode register with 16-bit mode and
// marks the accumulator for a restart. A stall on the output holds the input
// register, and the input side stays ready while that register is free.
module table_dpcm_audio_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
	input  logic        s_axis_tlast,   // end_of_resource
	// Output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] sample (signed)
	output logic        m_axis_tlast,   // last_of_run
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data        // sixteen_bit_mode
);
	import tdad_pkg::*;

	// Configuration register.
	logic mode16_q;

	// Input register stage.
	logic              s1_valid_s1;
	logic [CODE_W-1:0] s1_byte_s1;
	logic              s1_eor_s1;
	logic              phase_q;

	// Accumulator and restart flag.
	logic signed [SAMPLE_W-1:0] acc_q;
	logic                       restart_q;

	// Output register.
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_last_q;

	step_ctl_t ctl;
	step_res_t res;
	logic      out_load;   // a step result is written to the output register
	logic      s1_done;    // the final sample of the held byte is written to the output register this cycle
	logic      s_accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode16_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			mode16_q <= cfg_data;
		end
	end

	// The datapath runs whenever a byte is held and the output register is
	// free or being emptied.
	assign out_load      = s1_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s1_done       = out_load && res.last;
	assign s_axis_tready = !s1_valid_s1 || s1_done;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	assign ctl.mode16  = mode16_q;
	assign ctl.restart = restart_q;
	assign ctl.phase   = phase_q;

	tdad_step u_step (
		.acc       (acc_q),
		.code_byte (s1_byte_s1),
		.ctl       (ctl),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			phase_q     <= 1'b0;
			restart_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_done) begin
				s1_valid_s1 <= 1'b0;
			end

			if (out_load) begin
				// The high nibble moves the phase on; the final sample clears it.
				phase_q   <= !res.last;
				restart_q <= res.last && s1_eor_s1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			s1_byte_s1 <= s_axis_tdata;
			s1_eor_s1  <= s_axis_tlast;
		end
		if (out_load) begin
			acc_q        <= res.sample;
			out_sample_q <= res.sample;
			out_last_q   <= res.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_sample_q;
	assign m_axis_tlast  = out_last_q;

	// A high-nibble sample on the output means its byte still waits in the
	// input register for the low nibble.
	a_first_nibble_holds_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_last_q |-> s1_valid_s1 && phase_q)
		else $error("high-nibble sample shown without its byte held");

	// The phase only ever points at a held byte.
	a_phase_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> s1_valid_s1)
		else $error("nibble phase set with an empty input register");

	// Finishing the last byte of a resource arms the restart.
	a_restart_after_eor: assert property (@(posedge clk) disable iff (!arst_n)
		s1_done && s1_eor_s1 |=> restart_q)
		else $error("restart not armed after end of resource");

	// A byte is never accepted while the held one still has a sample to give.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !s1_done |-> !s_axis_tready)
		else $error("input accepted over a byte still in work");

endmodule

### tb/tb_table_dpcm_audio_decoder_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for table_dpcm_audio_decoder_top, driving code bytes and mode
// writes with random idling and checking every sample beat. Depends on the RTL alone.
module tb_table_dpcm_audio_decoder_top;

	// Values of the mode register.
	localparam bit MODE_8BIT  = 1'b0;
	localparam bit MODE_16BIT = 1'b1;

	// Accumulator start values and limits of the two modes.
	localparam int START_16BIT = 0;
	localparam int START_8BIT  = 128;
	localparam int SAT_MIN     = -32768;
	localparam int SAT_MAX     = 32767;
	localparam int CLAMP_MIN   = 0;
	localparam int CLAMP_MAX   = 255;

	localparam int RANDOM_BYTES  = 800;
	localparam int DRAIN_CYCLES  = 20;
	localparam int DIRECTED_ROWS = 26;

	// Step sizes of the 16-bit mode, indexed by the low seven bits of a code byte.
	localparam logic [15:0] DELTA16 [128] = '{
		16'h0000, 16'h0008, 16'h0010, 16'h0020, 16'h0030, 16'h0040, 16'h0050, 16'h0060,
		16'h0070, 16'h0080, 16'h0090, 16'h00A0, 16'h00B0, 16'h00C0, 16'h00D0, 16'h00E0,
		16'h00F0, 16'h0100, 16'h0110, 16'h0120, 16'h0130, 16'h0140, 16'h0150, 16'h0160,
		16'h0170, 16'h0180, 16'h0190, 16'h01A0, 16'h01B0, 16'h01C0, 16'h01D0, 16'h01E0,
		16'h01F0, 16'h0200, 16'h0208, 16'h0210, 16'h0218, 16'h0220, 16'h0228, 16'h0230,
		16'h0238, 16'h0240, 16'h0248, 16'h0250, 16'h0258, 16'h0260, 16'h0268, 16'h0270,
		16'h0278, 16'h0280, 16'h0288, 16'h0290, 16'h0298, 16'h02A0, 16'h02A8, 16'h02B0,
		16'h02B8, 16'h02C0, 16'h02C8, 16'h02D0, 16'h02D8, 16'h02E0, 16'h02E8, 16'h02F0,
		16'h02F8, 16'h0300, 16'h0308, 16'h0310, 16'h0318, 16'h0320, 16'h0328, 16'h0330,
		16'h0338, 16'h0340, 16'h0348, 16'h0350, 16'h0358, 16'h0360, 16'h0368, 16'h0370,
		16'h0378, 16'h0380, 16'h0388, 16'h0390, 16'h0398, 16'h03A0, 16'h03A8, 16'h03B0,
		16'h03B8, 16'h03C0, 16'h03C8, 16'h03D0, 16'h03D8, 16'h03E0, 16'h03E8, 16'h03F0,
		16'h03F8, 16'h0400, 16'h0440, 16'h0480, 16'h04C0, 16'h0500, 16'h0540, 16'h0580,
		16'h05C0, 16'h0600, 16'h0640, 16'h0680, 16'h06C0, 16'h0700, 16'h0740, 16'h0780,
		16'h07C0, 16'h0800, 16'h0900, 16'h0A00, 16'h0B00, 16'h0C00, 16'h0D00, 16'h0E00,
		16'h0F00, 16'h1000, 16'h1400, 16'h1800, 16'h1C00, 16'h2000, 16'h3000, 16'h4000
	};

	// Step sizes of the 8-bit nibble mode.
	localparam int DELTA8 [8] = '{0, 1, 2, 3, 6, 10, 15, 21};

	// One sample beat as the decoder should present it.
	typedef struct packed {
		logic [15:0] sample;
		logic        last;
	} sample_beat_t;

	// A row of the directed stimulus. Where typed is set, the final sample of the byte
	// is the value written here rather than the one the predictor works out.
	typedef struct packed {
		logic        mode;
		logic [7:0]  code;
		logic        eor;
		logic        typed;
		logic [15:0] final_sample;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] code_byte
	logic        s_axis_tlast = 1'b0;    // end_of_resource
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // [15:0] sample (signed)
	logic        m_axis_tlast;           // last_of_run
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;        // sixteen_bit_mode

	// Predictor state: the mode register, the accumulator and the restart flag.
	logic               mode_q = MODE_16BIT;
	logic signed [15:0] running_sample_q = 16'sd0;
	logic               restart_due = 1'b1;

	sample_beat_t pending_samples [$];
	int           mismatch_count = 0;
	bit           tx_quiet = 1'b0;
	bit           rx_quiet = 1'b0;

	// The directed rows walk through the special cases in order:
	// the first byte after reset starts from zero, then both ends of the 16-bit range
	// are driven into saturation, a resource ends and the next restarts from zero,
	// the 8-bit mode starts from 128 and is pushed against 255 and then 0 (including
	// the subtract nibble with index 7, which steps by nothing), the mode changes inside
	// a resource so a negative 16-bit value meets the 8-bit clamp, and finally the mode
	// changes between resources so the restart takes the new mode's start value.
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{MODE_16BIT, 8'h00, 1'b0, 1'b1, 16'h0000},
		'{MODE_16BIT, 8'h7F, 1'b0, 1'b1, 16'h4000},
		'{MODE_16BIT, 8'h7F, 1'b0, 1'b1, 16'h7FFF},
		'{MODE_16BIT, 8'h7F, 1'b0, 1'b1, 16'h7FFF},
		'{MODE_16BIT, 8'h80, 1'b0, 1'b1, 16'h7FFF},
		'{MODE_16BIT, 8'hFF, 1'b1, 1'b1, 16'h3FFF},
		'{MODE_16BIT, 8'hFF, 1'b0, 1'b1, 16'hC000},
		'{MODE_16BIT, 8'hFF, 1'b0, 1'b1, 16'h8000},
		'{MODE_16BIT, 8'hFF, 1'b0, 1'b1, 16'h8000},
		'{MODE_16BIT, 8'h01, 1'b1, 1'b0, 16'h0000},
		'{MODE_8BIT,  8'h00, 1'b0, 1'b1, 16'd128},
		'{MODE_8BIT,  8'h77, 1'b0, 1'b1, 16'd170},
		'{MODE_8BIT,  8'h77, 1'b0, 1'b1, 16'd212},
		'{MODE_8BIT,  8'h77, 1'b0, 1'b1, 16'd254},
		'{MODE_8BIT,  8'h77, 1'b0, 1'b1, 16'd255},
		'{MODE_8BIT,  8'h88, 1'b0, 1'b1, 16'd213},
		'{MODE_8BIT,  8'hFF, 1'b0, 1'b1, 16'd213},
		'{MODE_8BIT,  8'h88, 1'b1, 1'b0, 16'd0},
		'{MODE_8BIT,  8'h88, 1'b0, 1'b1, 16'd86},
		'{MODE_8BIT,  8'h88, 1'b0, 1'b1, 16'd44},
		'{MODE_8BIT,  8'h88, 1'b0, 1'b1, 16'd2},
		'{MODE_8BIT,  8'h88, 1'b0, 1'b1, 16'd0},
		'{MODE_16BIT, 8'h01, 1'b0, 1'b1, 16'd8},
		'{MODE_16BIT, 8'hFF, 1'b0, 1'b1, 16'hC008},
		'{MODE_8BIT,  8'h01, 1'b1, 1'b1, 16'd1},
		'{MODE_16BIT, 8'h00, 1'b0, 1'b1, 16'd0}
	};

	table_dpcm_audio_decoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One nibble step of the 8-bit mode. A set top bit subtracts, with the table read
	// from the far end, so nibble 8 takes the largest step and nibble 15 takes none.
	function automatic int apply_nibble(int acc, logic [3:0] nib);
		int sum;
		if (nib[3]) begin
			sum = acc - DELTA8[7 - nib[2:0]];
		end else begin
			sum = acc + DELTA8[nib[2:0]];
		end
		if (sum < CLAMP_MIN) begin
			return CLAMP_MIN;
		end
		if (sum > CLAMP_MAX) begin
			return CLAMP_MAX;
		end
		return sum;
	endfunction

	// Appends one predicted beat at the tail of the queue.
	function automatic void queue_sample(sample_beat_t beat);
		pending_samples = {pending_samples, beat};
	endfunction

	// Works out the sample beats of one accepted code byte, queues them and advances
	// the accumulator. A pending restart loads the start value of the mode now in force.
	function automatic void decode_code_byte(logic [7:0] code, logic eor);
		int acc;
		if (restart_due) begin
			running_sample_q = (mode_q == MODE_16BIT) ? 16'(START_16BIT) : 16'(START_8BIT);
			restart_due = 1'b0;
		end
		acc = int'(running_sample_q);
		if (mode_q == MODE_16BIT) begin
			if (code[7]) begin
				acc = acc - int'(DELTA16[code[6:0]]);
			end else begin
				acc = acc + int'(DELTA16[code[6:0]]);
			end
			if (acc < SAT_MIN) begin
				acc = SAT_MIN;
			end else if (acc > SAT_MAX) begin
				acc = SAT_MAX;
			end
			queue_sample('{acc[15:0], 1'b1});
		end else begin
			acc = apply_nibble(acc, code[7:4]);
			queue_sample('{acc[15:0], 1'b0});
			acc = apply_nibble(acc, code[3:0]);
			queue_sample('{acc[15:0], 1'b1});
		end
		running_sample_q = acc[15:0];
		if (eor) begin
			restart_due = 1'b1;
		end
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Offers one code byte after a random gap and holds it until the beat is taken.
	// The prediction is made at the edge of acceptance.
	task automatic send_code_byte(input logic [7:0] code, input logic eor);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= code;
		s_axis_tlast  <= eor;
		do @(posedge clk); while (!s_axis_tready);
		decode_code_byte(code, eor);
	endtask

	// Holds the input quiet until every predicted sample has come out.
	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
	endtask

	// Writes the mode register. The decoder is drained first, so no byte is in flight.
	task automatic write_mode(input logic mode);
		wait_for_drain();
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mode_q = mode;
	endtask

	// Output side: a random stall before each beat, with the odd stretch of none at all.
	initial begin : sample_sink
		int stall;
		forever begin
			if ($urandom_range(0, 49) == 0) begin
				rx_quiet = !rx_quiet;
			end
			stall = rx_quiet ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// Every sample beat is compared with the oldest prediction, field by field.
	always @(posedge clk) begin
		sample_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_samples.size() == 0) begin
				report_mismatch($sformatf("sample beat %h/%b with none predicted",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = pending_samples.pop_front();
				if (m_axis_tdata !== want.sample) begin
					report_mismatch($sformatf("sample %h, predicted %h",
						m_axis_tdata, want.sample));
				end
				if (m_axis_tlast !== want.last) begin
					report_mismatch($sformatf("last_of_run %b, predicted %b",
						m_axis_tlast, want.last));
				end
			end
		end
	end

	initial begin : stimulus
		int sent;
		int phase_len;
		int drift;
		logic [7:0] code;
		logic eor;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The register is written up front and again at each change
		// of mode in the table.
		write_mode(directed_rows[0].mode);
		foreach (directed_rows[i]) begin
			if (directed_rows[i].mode != mode_q) begin
				write_mode(directed_rows[i].mode);
			end
			send_code_byte(directed_rows[i].code, directed_rows[i].eor);
			if (directed_rows[i].typed) begin
				pending_samples[$].sample = directed_rows[i].final_sample;
			end
		end

		// Random part, in phases of one mode each. A phase may drift upwards or
		// downwards so that the accumulator spends time against its limits.
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			write_mode(1'($urandom_range(0, 1)));
			tx_quiet  = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(10, 120);
			drift     = $urandom_range(0, 3);
			repeat (phase_len) begin
				code = 8'($urandom_range(0, 255));
				eor  = ($urandom_range(0, 9) == 0);
				if (drift == 2) begin
					code &= (mode_q == MODE_16BIT) ? 8'h7F : 8'h77;
				end else if (drift == 3) begin
					code |= (mode_q == MODE_16BIT) ? 8'h80 : 8'h88;
				end
				send_code_byte(code, eor);
				sent++;
			end
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Far beyond the slowest correct run: every gap and stall at its longest.
	initial begin : watchdog
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
